// File: rtl/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// types, scan code constants and the azerty key maps of the decoder
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int MAP_ENTRIES = 58;

    // modifier tracking state
    typedef struct packed {
        logic       shift_held;
        logic       ctrl_held;
        logic       ctrl_armed;
        logic [2:0] release_tally;
    } t_mod_state;

    // scan codes, set 1
    localparam logic [7:0] SC_ESC         = 8'h01;
    localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
    localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_UP          = 8'h48;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;
    localparam logic [7:0] SC_DOWN        = 8'h50;
    localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;

    // output character codes
    localparam logic [6:0] CH_NONE      = 7'd0;
    localparam logic [6:0] CH_ESC       = 7'd27;
    localparam logic [6:0] CH_BACKSPACE = 7'd8;
    localparam logic [6:0] CH_UP        = 7'd16;
    localparam logic [6:0] CH_DOWN      = 7'd14;
    localparam logic [6:0] CH_LEFT      = 7'd17;
    localparam logic [6:0] CH_RIGHT     = 7'd18;
    localparam logic [6:0] CH_CTRL_C    = 7'd3;
    localparam logic [6:0] CH_CTRL_S    = 7'd19;
    localparam logic [6:0] CH_CTRL_Q    = 7'd17;
    localparam logic [6:0] CH_LO_C      = 7'd99;
    localparam logic [6:0] CH_UP_C      = 7'd67;
    localparam logic [6:0] CH_LO_S      = 7'd115;
    localparam logic [6:0] CH_UP_S      = 7'd83;
    localparam logic [6:0] CH_LO_Q      = 7'd113;
    localparam logic [6:0] CH_UP_Q      = 7'd81;

    // unshifted azerty map
    localparam logic [6:0] PLAIN_MAP [0:MAP_ENTRIES-1] = '{
        7'd0,   7'd27,  7'd38,  7'd101, 7'd34,  7'd39,  7'd40,  7'd45,
        7'd101, 7'd95,  7'd99,  7'd97,  7'd41,  7'd61,  7'd8,   7'd9,
        7'd97,  7'd122, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
        7'd111, 7'd112, 7'd94,  7'd36,  7'd10,  7'd0,
        7'd113, 7'd115, 7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107,
        7'd108, 7'd109, 7'd117, 7'd42,  7'd0,   7'd42,
        7'd119, 7'd120, 7'd99,  7'd118, 7'd98,  7'd110, 7'd44,  7'd59,
        7'd58,  7'd33,  7'd0,   7'd42,  7'd0,   7'd32
    };

    // shifted azerty map
    localparam logic [6:0] SHIFTED_MAP [0:MAP_ENTRIES-1] = '{
        7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
        7'd55,  7'd56,  7'd57,  7'd48,  7'd43,  7'd61,  7'd8,   7'd9,
        7'd65,  7'd90,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
        7'd79,  7'd80,  7'd91,  7'd93,  7'd10,  7'd0,
        7'd81,  7'd83,  7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,
        7'd76,  7'd77,  7'd37,  7'd126, 7'd0,   7'd35,
        7'd87,  7'd88,  7'd67,  7'd86,  7'd66,  7'd78,  7'd63,  7'd46,
        7'd47,  7'd115, 7'd0,   7'd42,  7'd0,   7'd32
    };

    // key map lookup, codes past the map give zero
    function automatic logic [6:0] map_lookup(input logic shift, input logic [6:0] idx);
        logic [6:0] val;
        val = CH_NONE;
        if (idx < 7'(MAP_ENTRIES)) begin
            val = shift ? SHIFTED_MAP[idx[5:0]] : PLAIN_MAP[idx[5:0]];
        end
        return val;
    endfunction

endpackage

// File: rtl/scd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_decode
// one scan code against the modifier state: next state and character
// ----------------------------------------------------------------------------
module scd_decode (
    input  logic [7:0]          i_code,
    input  scd_pkg::t_mod_state i_state,
    input  logic [2:0]          i_limit,
    output scd_pkg::t_mod_state o_state,
    output logic                o_hit,
    output logic [6:0]          o_char
);

    logic [6:0] map_char;
    logic [3:0] tally_inc;

    assign map_char  = scd_pkg::map_lookup(i_state.shift_held, i_code[6:0]);
    assign tally_inc = {1'b0, i_state.release_tally} + 4'd1;

    always_comb begin
        o_state = i_state;
        o_hit   = 1'b0;
        o_char  = scd_pkg::CH_NONE;
        if (i_code == scd_pkg::SC_LSHIFT_MAKE || i_code == scd_pkg::SC_RSHIFT_MAKE) begin
            o_state.shift_held = 1'b1;
        end else if (i_code == scd_pkg::SC_LSHIFT_BRK ||
                     i_code == scd_pkg::SC_RSHIFT_BRK) begin
            o_state.shift_held = 1'b0;
        end else if (i_code == scd_pkg::SC_CTRL_MAKE) begin
            o_state.ctrl_held  = 1'b1;
            o_state.ctrl_armed = 1'b1;
        end else if (i_code == scd_pkg::SC_CTRL_BREAK) begin
            o_state.ctrl_held  = 1'b0;
            o_state.ctrl_armed = 1'b0;
        end else if (i_code[7]) begin
            // release of another key counts toward forcing ctrl off
            if (i_state.ctrl_held && i_state.ctrl_armed) begin
                if (tally_inc > {1'b0, i_limit}) begin
                    o_state.ctrl_held     = 1'b0;
                    o_state.ctrl_armed    = 1'b0;
                    o_state.release_tally = 3'd0;
                end else begin
                    o_state.release_tally = tally_inc[2:0];
                end
            end
        end else begin
            case (i_code)
                scd_pkg::SC_ESC: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_ESC;
                end
                scd_pkg::SC_BACKSPACE: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_BACKSPACE;
                end
                scd_pkg::SC_UP: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_UP;
                end
                scd_pkg::SC_DOWN: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_DOWN;
                end
                scd_pkg::SC_LEFT: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_LEFT;
                end
                scd_pkg::SC_RIGHT: begin
                    o_hit  = 1'b1;
                    o_char = scd_pkg::CH_RIGHT;
                end
                default: begin
                    if (i_state.ctrl_held &&
                        (map_char == scd_pkg::CH_LO_C || map_char == scd_pkg::CH_UP_C)) begin
                        o_state.ctrl_held = 1'b0;
                        o_hit             = 1'b1;
                        o_char            = scd_pkg::CH_CTRL_C;
                    end else if (i_state.ctrl_held &&
                        (map_char == scd_pkg::CH_LO_S || map_char == scd_pkg::CH_UP_S)) begin
                        o_state.ctrl_held = 1'b0;
                        o_hit             = 1'b1;
                        o_char            = scd_pkg::CH_CTRL_S;
                    end else if (i_state.ctrl_held &&
                        (map_char == scd_pkg::CH_LO_Q || map_char == scd_pkg::CH_UP_Q)) begin
                        o_state.ctrl_held = 1'b0;
                        o_hit             = 1'b1;
                        o_char            = scd_pkg::CH_CTRL_Q;
                    end else if (map_char != scd_pkg::CH_NONE) begin
                        o_hit  = 1'b1;
                        o_char = map_char;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/scancode_to_char_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_char_decoder_core
// set-1 scan code bytes in, azerty characters and control codes out
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[7:0] scan code
//  m_axis    | out       | tdata[6:0] char code, tdata[7] zero
//  cfg       | in        | wr_data[2:0] ctrl release limit
//
// one request per cycle while the result register is free or draining; each accepted
// request passes the input register, then decode into the result register
// modifier state is updated in order as each request passes the decode stage
// requests that give no character update state and leave no result
// a stalled result register holds the input register; input backs up when both are full
// synchronous active-low reset clears the modifiers and sets the limit to 5
// ----------------------------------------------------------------------------
module scancode_to_char_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] scan_code
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] char_code, [7] zero fill
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data     // [2:0] ctrl_release_limit
);

    // configuration
    logic [2:0] r_ctrl_release_limit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_code;

    // modifier state
    scd_pkg::t_mod_state r_state;
    scd_pkg::t_mod_state n_state;

    // result register
    logic       r_out_valid;
    logic [6:0] r_out_char;

    logic       n_hit;
    logic [6:0] n_char;
    logic       advance;

    // the decode stage moves whenever the result register is free or draining
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_char};

    scd_decode u_decode (
        .i_code  (r_in_code),
        .i_state (r_state),
        .i_limit (r_ctrl_release_limit),
        .o_state (n_state),
        .o_hit   (n_hit),
        .o_char  (n_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_release_limit <= 3'd5;
        end else if (i_cfg_wr_en) begin
            r_ctrl_release_limit <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_code <= i_s_axis_tdata;
        end
    end

    // modifier state, committed as each request is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_hit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= n_char;
        end
    end

    // a zero character is never delivered
    a_no_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[6:0] != scd_pkg::CH_NONE))
        else $error("zero character delivered");

    // ctrl is only ever held while release counting is armed
    a_ctrl_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ctrl_held |-> r_state.ctrl_armed)
        else $error("ctrl held without armed");

    // reset empties the input and result registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule
